// File: src/tsni_pkg.sv
// ----------------------------------------------------------------------------
// tsni_pkg
// Types and constants shared by the SNI host name masker modules.
// ----------------------------------------------------------------------------
package tsni_pkg;

  // Parser phases, one-hot
  typedef enum logic [18:0] {
    PH_REC0      = 19'h00001,
    PH_CCS       = 19'h00002,
    PH_REC1      = 19'h00004,
    PH_HS_HDR    = 19'h00008,
    PH_HELLO     = 19'h00010,
    PH_SID_LEN   = 19'h00020,
    PH_SKIP_SID  = 19'h00040,
    PH_CS_LEN    = 19'h00080,
    PH_SKIP_CS   = 19'h00100,
    PH_COMP_LEN  = 19'h00200,
    PH_SKIP_COMP = 19'h00400,
    PH_EXT_TOTAL = 19'h00800,
    PH_EXT_HDR   = 19'h01000,
    PH_EXT_SKIP  = 19'h02000,
    PH_SNI_LEN   = 19'h04000,
    PH_NAME_HDR  = 19'h08000,
    PH_NAME      = 19'h10000,
    PH_DONE      = 19'h20000,
    PH_ERR       = 19'h40000
  } phase_t;

  // Phases that consume handshake record body bytes
  localparam logic [18:0] PH_IN_RECORD = 19'h3FFF0;
  // Phases inside the extensions block / one extension / the SNI list
  localparam logic [18:0] PH_IN_EXTS   = 19'h1F000;
  localparam logic [18:0] PH_IN_EXT    = 19'h1E000;
  localparam logic [18:0] PH_IN_SNI    = 19'h18000;

  // Status codes reported on the last item
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_NOT_HS     = 3'd1;
  localparam logic [2:0] ST_NOT_HELLO  = 3'd2;
  localparam logic [2:0] ST_OVERRUN    = 3'd3;
  localparam logic [2:0] ST_TRUNCATED  = 3'd4;

  // Configuration register indexes
  localparam logic CFG_MASK_CHAR   = 1'b0;
  localparam logic CFG_MASK_ENABLE = 1'b1;

  localparam logic [7:0]  REC_CCS         = 8'h14;
  localparam logic [7:0]  REC_HANDSHAKE   = 8'h16;
  localparam logic [7:0]  HS_CLIENT_HELLO = 8'h01;
  localparam logic [7:0]  CCS_BODY        = 8'h01;
  localparam logic [15:0] EXT_SERVER_NAME = 16'h0000;
  localparam logic [23:0] MIN_RECORD_LEN  = 24'd38;
  localparam logic [5:0]  HELLO_LAST_IDX  = 6'd37;

  typedef struct packed {
    logic [7:0] mask_char;
    logic       mask_enable;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_out;
    logic       masked;
    logic       last_out;
    logic [2:0] status;
  } result_t;

endpackage

// File: src/tls_sni_hostname_masker.sv
// Pipeline: input register, one parse step, result register; one item per cycle
// sustained while the output is not stalled, no gap between items.
// A stalled output holds its result; the input stalls only when both registers are full.
// Reset (rst, synchronous): parser to record header start, mask_char to 'x',
// mask_enable to 1, both pipeline registers empty.
// ----------------------------------------------------------------------------
// tls_sni_hostname_masker
// Byte-stream ClientHello walker that overwrites SNI host names.
// ----------------------------------------------------------------------------
module tls_sni_hostname_masker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_out, [10:8] status, [15:11] zero
  output logic        m_axis_tuser,   // [0] masked
  output logic        m_axis_tlast
);

  tsni_pkg::cfg_t    cfg;
  tsni_pkg::result_t res;
  tsni_pkg::result_t out_data;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       out_valid;
  logic       advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mask_char   <= 8'h78;
      cfg.mask_enable <= 1'b1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsni_pkg::CFG_MASK_CHAR:   cfg.mask_char   <= cfg_wdata;
        tsni_pkg::CFG_MASK_ENABLE: cfg.mask_enable <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // step the parser whenever an item waits and the result slot is free
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  tsni_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .byte_in (in_byte),
    .last_in (in_last),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, out_data.status, out_data.byte_out};
  assign m_axis_tuser  = out_data.masked;
  assign m_axis_tlast  = out_data.last_out;

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[10:8] == tsni_pkg::ST_OK))
    else $error("status set on an item that is not last");

  a_step_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_axis_tvalid)
    else $error("parsed item did not reach the output register");

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !advance) |=> in_valid)
    else $error("waiting input item lost");

endmodule

// File: src/tsni_parser.sv
// ----------------------------------------------------------------------------
// tsni_parser
// ClientHello walker: holds the parse state and works out one result per byte.
// ----------------------------------------------------------------------------
module tsni_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        byte_in,
  input  logic              last_in,
  input  tsni_pkg::cfg_t    cfg,
  output tsni_pkg::result_t res
);

  tsni_pkg::phase_t phase, phase_next, ph_eff, need_phase;
  logic [5:0]  fbc, fbc_next;
  logic [23:0] acc, acc_next;
  logic [15:0] rec, rec_next;
  logic [15:0] exts, exts_next;
  logic [15:0] ext, ext_next;
  logic [15:0] etype, etype_next;
  logic [15:0] sni, sni_next;
  logic [15:0] name_rem, name_rem_next;
  logic        host, host_next;
  logic [2:0]  err, err_next;

  logic        fail_req;
  logic [2:0]  fail_code;
  logic        need_req;
  logic [15:0] need_avail;
  logic [2:0]  need_min;
  logic        next_name_req;
  logic        end_ext_req;

  always_comb begin
    phase_next    = phase;
    fbc_next      = fbc;
    acc_next      = acc;
    rec_next      = rec;
    exts_next     = exts;
    ext_next      = ext;
    etype_next    = etype;
    sni_next      = sni;
    name_rem_next = name_rem;
    host_next     = host;
    err_next      = err;
    ph_eff        = phase;
    fail_req      = 1'b0;
    fail_code     = tsni_pkg::ST_OVERRUN;
    need_req      = 1'b0;
    need_avail    = '0;
    need_min      = '0;
    need_phase    = phase;
    next_name_req = 1'b0;
    end_ext_req   = 1'b0;
    res.byte_out  = byte_in;
    res.masked    = 1'b0;
    res.last_out  = last_in;
    res.status    = tsni_pkg::ST_OK;

    // count down every enclosing length on bytes of the handshake record
    if ((phase & tsni_pkg::PH_IN_RECORD) != '0) begin
      if (rec == '0) begin
        fail_req = 1'b1;
        ph_eff   = tsni_pkg::PH_ERR;
      end else begin
        rec_next = rec - 16'd1;
        if ((phase & tsni_pkg::PH_IN_EXTS) != '0 && exts != '0) exts_next = exts - 16'd1;
        if ((phase & tsni_pkg::PH_IN_EXT) != '0 && ext != '0) ext_next = ext - 16'd1;
        if ((phase & tsni_pkg::PH_IN_SNI) != '0 && sni != '0) sni_next = sni - 16'd1;
        if (phase == tsni_pkg::PH_NAME && name_rem != '0) name_rem_next = name_rem - 16'd1;
      end
    end

    unique case (ph_eff)
      tsni_pkg::PH_REC0, tsni_pkg::PH_REC1: begin
        if (ph_eff == tsni_pkg::PH_REC0 && byte_in == tsni_pkg::REC_CCS) begin
          phase_next = tsni_pkg::PH_CCS;
          fbc_next   = 6'd1;
          acc_next   = '0;
        end else if (byte_in == tsni_pkg::REC_HANDSHAKE) begin
          phase_next = tsni_pkg::PH_HS_HDR;
          fbc_next   = 6'd1;
          acc_next   = '0;
        end else begin
          fail_req  = 1'b1;
          fail_code = tsni_pkg::ST_NOT_HS;
        end
      end
      tsni_pkg::PH_CCS: begin
        fbc_next = fbc + 6'd1;
        if (fbc == 6'd3 || fbc == 6'd4) acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd4 && acc_next != 24'd1) begin
          fail_req  = 1'b1;
          fail_code = tsni_pkg::ST_NOT_HS;
        end else if (fbc >= 6'd5) begin
          if (byte_in != tsni_pkg::CCS_BODY) begin
            fail_req  = 1'b1;
            fail_code = tsni_pkg::ST_NOT_HS;
          end else begin
            phase_next = tsni_pkg::PH_REC1;
          end
        end
      end
      tsni_pkg::PH_HS_HDR: begin
        fbc_next = fbc + 6'd1;
        if (fbc >= 6'd3) acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc >= 6'd4) begin
          if (acc_next < tsni_pkg::MIN_RECORD_LEN) begin
            fail_req = 1'b1;
          end else begin
            rec_next   = acc_next[15:0];
            phase_next = tsni_pkg::PH_HELLO;
            fbc_next   = '0;
            acc_next   = '0;
          end
        end
      end
      tsni_pkg::PH_HELLO: begin
        fbc_next = fbc + 6'd1;
        if (fbc == 6'd0) begin
          if (byte_in != tsni_pkg::HS_CLIENT_HELLO) begin
            fail_req  = 1'b1;
            fail_code = tsni_pkg::ST_NOT_HELLO;
          end
        end else if (fbc <= 6'd3) begin
          acc_next = {acc[15:0], byte_in};
          if (fbc == 6'd3 && acc_next < {8'd0, rec_next}) fail_req = 1'b1;
        end else if (fbc >= tsni_pkg::HELLO_LAST_IDX) begin
          need_req   = 1'b1;
          need_avail = rec_next;
          need_min   = 3'd1;
          need_phase = tsni_pkg::PH_SID_LEN;
        end
      end
      tsni_pkg::PH_SID_LEN, tsni_pkg::PH_COMP_LEN: begin
        if ({8'd0, byte_in} > rec_next) begin
          fail_req = 1'b1;
        end else if (byte_in != '0) begin
          acc_next   = {16'd0, byte_in};
          phase_next = (ph_eff == tsni_pkg::PH_SID_LEN) ? tsni_pkg::PH_SKIP_SID
                                                         : tsni_pkg::PH_SKIP_COMP;
        end else begin
          need_req   = 1'b1;
          need_avail = rec_next;
          need_min   = 3'd2;
          need_phase = (ph_eff == tsni_pkg::PH_SID_LEN) ? tsni_pkg::PH_CS_LEN
                                                         : tsni_pkg::PH_EXT_TOTAL;
        end
      end
      tsni_pkg::PH_SKIP_SID, tsni_pkg::PH_SKIP_CS, tsni_pkg::PH_SKIP_COMP: begin
        if (acc != '0) acc_next = acc - 24'd1;
        if (acc_next == '0) begin
          need_req   = 1'b1;
          need_avail = rec_next;
          unique case (ph_eff)
            tsni_pkg::PH_SKIP_SID: begin
              need_min   = 3'd2;
              need_phase = tsni_pkg::PH_CS_LEN;
            end
            tsni_pkg::PH_SKIP_CS: begin
              need_min   = 3'd1;
              need_phase = tsni_pkg::PH_COMP_LEN;
            end
            default: begin
              need_min   = 3'd2;
              need_phase = tsni_pkg::PH_EXT_TOTAL;
            end
          endcase
        end
      end
      tsni_pkg::PH_CS_LEN: begin
        fbc_next = fbc + 6'd1;
        acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd1) begin
          if (acc_next > {8'd0, rec_next}) begin
            fail_req = 1'b1;
          end else if (acc_next != '0) begin
            phase_next = tsni_pkg::PH_SKIP_CS;
          end else begin
            need_req   = 1'b1;
            need_avail = rec_next;
            need_min   = 3'd1;
            need_phase = tsni_pkg::PH_COMP_LEN;
          end
        end
      end
      tsni_pkg::PH_EXT_TOTAL: begin
        fbc_next = fbc + 6'd1;
        acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd1) begin
          if (acc_next > {8'd0, rec_next}) begin
            fail_req = 1'b1;
          end else begin
            exts_next   = acc_next[15:0];
            end_ext_req = 1'b1;
          end
        end
      end
      tsni_pkg::PH_EXT_HDR: begin
        fbc_next = fbc + 6'd1;
        if (fbc == 6'd0) etype_next = {8'd0, byte_in};
        else if (fbc == 6'd1) etype_next = {etype[7:0], byte_in};
        else acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd3) begin
          if (acc_next > {8'd0, exts_next}) begin
            fail_req = 1'b1;
          end else begin
            ext_next = acc_next[15:0];
            if (etype_next == tsni_pkg::EXT_SERVER_NAME) begin
              need_req   = 1'b1;
              need_avail = ext_next;
              need_min   = 3'd2;
              need_phase = tsni_pkg::PH_SNI_LEN;
            end else if (ext_next != '0) begin
              phase_next = tsni_pkg::PH_EXT_SKIP;
            end else begin
              end_ext_req = 1'b1;
            end
          end
        end
      end
      tsni_pkg::PH_EXT_SKIP: begin
        if (ext_next == '0) end_ext_req = 1'b1;
      end
      tsni_pkg::PH_SNI_LEN: begin
        fbc_next = fbc + 6'd1;
        acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd1) begin
          if (acc_next > {8'd0, ext_next}) begin
            fail_req = 1'b1;
          end else begin
            sni_next      = acc_next[15:0];
            next_name_req = 1'b1;
          end
        end
      end
      tsni_pkg::PH_NAME_HDR: begin
        fbc_next = fbc + 6'd1;
        if (fbc == 6'd0) host_next = (byte_in == '0);
        else acc_next = {8'd0, acc[7:0], byte_in};
        if (fbc == 6'd2) begin
          if (acc_next > {8'd0, sni_next}) begin
            fail_req = 1'b1;
          end else begin
            name_rem_next = acc_next[15:0];
            if (name_rem_next != '0) phase_next = tsni_pkg::PH_NAME;
            else next_name_req = 1'b1;
          end
        end
      end
      tsni_pkg::PH_NAME: begin
        if (host && cfg.mask_enable) begin
          res.byte_out = cfg.mask_char;
          res.masked   = 1'b1;
        end
        if (name_rem_next == '0) next_name_req = 1'b1;
      end
      default: begin
      end
    endcase

    // end of one name: next entry, rest of the extension, or next extension
    if (next_name_req) begin
      if (sni_next != '0) begin
        need_req   = 1'b1;
        need_avail = sni_next;
        need_min   = 3'd3;
        need_phase = tsni_pkg::PH_NAME_HDR;
      end else if (ext_next != '0) begin
        phase_next = tsni_pkg::PH_EXT_SKIP;
      end else begin
        end_ext_req = 1'b1;
      end
    end

    if (end_ext_req) begin
      if (exts_next == '0) begin
        phase_next = tsni_pkg::PH_DONE;
      end else begin
        need_req   = 1'b1;
        need_avail = exts_next;
        need_min   = 3'd4;
        need_phase = tsni_pkg::PH_EXT_HDR;
      end
    end

    // next header must fit in what is left of its container
    if (need_req) begin
      if (need_avail < {13'd0, need_min}) begin
        fail_req = 1'b1;
      end else begin
        phase_next = need_phase;
        fbc_next   = '0;
        acc_next   = '0;
      end
    end

    // first error wins
    if (fail_req) begin
      if (err == tsni_pkg::ST_OK) err_next = fail_code;
      phase_next = tsni_pkg::PH_ERR;
    end

    if (last_in) begin
      priority if (phase_next == tsni_pkg::PH_ERR) res.status = err_next;
      else if (phase_next == tsni_pkg::PH_DONE) res.status = tsni_pkg::ST_OK;
      else res.status = tsni_pkg::ST_TRUNCATED;
      phase_next    = tsni_pkg::PH_REC0;
      fbc_next      = '0;
      acc_next      = '0;
      rec_next      = '0;
      exts_next     = '0;
      ext_next      = '0;
      etype_next    = '0;
      sni_next      = '0;
      name_rem_next = '0;
      host_next     = 1'b0;
      err_next      = tsni_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= tsni_pkg::PH_REC0;
      fbc      <= '0;
      acc      <= '0;
      rec      <= '0;
      exts     <= '0;
      ext      <= '0;
      etype    <= '0;
      sni      <= '0;
      name_rem <= '0;
      host     <= 1'b0;
      err      <= tsni_pkg::ST_OK;
    end else if (step) begin
      phase    <= phase_next;
      fbc      <= fbc_next;
      acc      <= acc_next;
      rec      <= rec_next;
      exts     <= exts_next;
      ext      <= ext_next;
      etype    <= etype_next;
      sni      <= sni_next;
      name_rem <= name_rem_next;
      host     <= host_next;
      err      <= err_next;
    end
  end

endmodule

// File: verif/tls_sni_hostname_masker_tb.sv
// ----------------------------------------------------------------------------
// tls_sni_hostname_masker_tb
// Drives TLS record streams through the masker, one byte per item.
// Streams are mostly generated ClientHello records with random content, some
// with deliberate faults, and some short noise streams. Each output item is
// checked against a parser model kept alongside the block. The mask settings
// change between runs, and the sender and the receiver idle at several rates.
// ----------------------------------------------------------------------------
module tls_sni_hostname_masker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] octets_t[$];

  typedef enum int {
    F_NONE, F_FLIP, F_TRUNCATE, F_PAD_CUT, F_PAST_RECORD,
    F_SHORT_HELLO, F_LONG_HELLO, F_EXT_OVERRUN
  } hello_fault_t;
  localparam int FAULT_KINDS = 8;

  localparam int RUNS = 5;
  localparam int BYTES_PER_RUN = 360;
  localparam int GAP_PCT[RUNS]   = '{0, 85, 0, 6, 30};
  localparam int STALL_PCT[RUNS] = '{0, 0, 85, 6, 30};

  // Parser model plus the queue of output items still owed by the block
  class sni_mask_scoreboard;
    logic [7:0]         mask_char;
    logic               mask_enable;
    tsni_pkg::phase_t   phase;
    bit   [5:0]         field_idx;
    bit   [23:0]        len_acc;
    bit   [15:0]        record_left;
    bit   [15:0]        exts_left;
    bit   [15:0]        ext_left;
    bit   [15:0]        ext_type;
    bit   [15:0]        list_left;
    bit   [15:0]        name_left;
    bit                 host_name;
    logic [2:0]         first_error;
    tsni_pkg::result_t  owed_q[$];
    int unsigned        failures;

    function new();
      mask_char = 8'h78;
      mask_enable = 1'b1;
      failures = 0;
      restart();
    endfunction

    function void restart();
      phase = tsni_pkg::PH_REC0;
      field_idx = '0;
      len_acc = '0;
      record_left = '0;
      exts_left = '0;
      ext_left = '0;
      ext_type = '0;
      list_left = '0;
      name_left = '0;
      host_name = 1'b0;
      first_error = tsni_pkg::ST_OK;
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == tsni_pkg::CFG_MASK_CHAR) mask_char = value;
      else mask_enable = value[0];
    endfunction

    function int unsigned outstanding();
      return owed_q.size();
    endfunction

    function void flag_error(logic [2:0] code);
      if (first_error == tsni_pkg::ST_OK) first_error = code;
      phase = tsni_pkg::PH_ERR;
    endfunction

    function void require(bit [15:0] avail, int unsigned need, tsni_pkg::phase_t nxt);
      if (avail < need) begin
        flag_error(tsni_pkg::ST_OVERRUN);
      end else begin
        phase = nxt;
        field_idx = '0;
        len_acc = '0;
      end
    endfunction

    function void close_extension();
      if (exts_left == 0) phase = tsni_pkg::PH_DONE;
      else require(exts_left, 4, tsni_pkg::PH_EXT_HDR);
    endfunction

    function void advance_name();
      if (list_left != 0) require(list_left, 3, tsni_pkg::PH_NAME_HDR);
      else if (ext_left != 0) phase = tsni_pkg::PH_EXT_SKIP;
      else close_extension();
    endfunction

    function void len8(logic [7:0] b, tsni_pkg::phase_t skip_ph, int unsigned need,
                       tsni_pkg::phase_t nxt);
      if (b > record_left) begin
        flag_error(tsni_pkg::ST_OVERRUN);
      end else if (b != 0) begin
        len_acc = {16'h0000, b};
        phase = skip_ph;
      end else begin
        require(record_left, need, nxt);
      end
    endfunction

    function void len16(logic [7:0] b, tsni_pkg::phase_t skip_ph, int unsigned need,
                        tsni_pkg::phase_t nxt);
      bit [5:0] idx;
      idx = field_idx;
      field_idx++;
      len_acc = {8'h00, len_acc[7:0], b};
      if (idx == 1) begin
        if (len_acc > record_left) flag_error(tsni_pkg::ST_OVERRUN);
        else if (len_acc != 0) phase = skip_ph;
        else require(record_left, need, nxt);
      end
    endfunction

    function void skip_step(int unsigned need, tsni_pkg::phase_t nxt);
      if (len_acc != 0) len_acc--;
      if (len_acc == 0) require(record_left, need, nxt);
    endfunction

    // Advance the parser by one stream byte and queue the output item it owes
    function void note_input(logic [7:0] b, logic last);
      tsni_pkg::result_t r;
      tsni_pkg::phase_t  ph;
      bit [5:0] idx;
      r.byte_out = b;
      r.masked = 1'b0;
      r.last_out = last;
      r.status = tsni_pkg::ST_OK;
      ph = phase;

      if ((ph & tsni_pkg::PH_IN_RECORD) != 0) begin
        if (record_left == 0) begin
          flag_error(tsni_pkg::ST_OVERRUN);
          ph = tsni_pkg::PH_ERR;
        end else begin
          record_left--;
          if ((ph & tsni_pkg::PH_IN_EXTS) != 0 && exts_left != 0) exts_left--;
          if ((ph & tsni_pkg::PH_IN_EXT) != 0 && ext_left != 0) ext_left--;
          if ((ph & tsni_pkg::PH_IN_SNI) != 0 && list_left != 0) list_left--;
          if (ph == tsni_pkg::PH_NAME && name_left != 0) name_left--;
        end
      end

      idx = field_idx;
      case (ph)
        tsni_pkg::PH_REC0, tsni_pkg::PH_REC1: begin
          if (ph == tsni_pkg::PH_REC0 && b == tsni_pkg::REC_CCS) begin
            phase = tsni_pkg::PH_CCS;
            field_idx = 6'd1;
            len_acc = '0;
          end else if (b == tsni_pkg::REC_HANDSHAKE) begin
            phase = tsni_pkg::PH_HS_HDR;
            field_idx = 6'd1;
            len_acc = '0;
          end else begin
            flag_error(tsni_pkg::ST_NOT_HS);
          end
        end
        tsni_pkg::PH_CCS: begin
          field_idx++;
          if (idx == 3 || idx == 4) len_acc = {8'h00, len_acc[7:0], b};
          if (idx == 4 && len_acc != 1) begin
            flag_error(tsni_pkg::ST_NOT_HS);
          end else if (idx >= 5) begin
            if (b != tsni_pkg::CCS_BODY) flag_error(tsni_pkg::ST_NOT_HS);
            else phase = tsni_pkg::PH_REC1;
          end
        end
        tsni_pkg::PH_HS_HDR: begin
          field_idx++;
          if (idx >= 3) len_acc = {8'h00, len_acc[7:0], b};
          if (idx >= 4) begin
            if (len_acc < tsni_pkg::MIN_RECORD_LEN) begin
              flag_error(tsni_pkg::ST_OVERRUN);
            end else begin
              record_left = len_acc[15:0];
              phase = tsni_pkg::PH_HELLO;
              field_idx = '0;
              len_acc = '0;
            end
          end
        end
        tsni_pkg::PH_HELLO: begin
          field_idx++;
          if (idx == 0) begin
            if (b != tsni_pkg::HS_CLIENT_HELLO) flag_error(tsni_pkg::ST_NOT_HELLO);
          end else if (idx <= 3) begin
            len_acc = {len_acc[15:0], b};
            if (idx == 3 && len_acc < record_left) flag_error(tsni_pkg::ST_OVERRUN);
          end else if (idx >= tsni_pkg::HELLO_LAST_IDX) begin
            require(record_left, 1, tsni_pkg::PH_SID_LEN);
          end
        end
        tsni_pkg::PH_SID_LEN:   len8(b, tsni_pkg::PH_SKIP_SID, 2, tsni_pkg::PH_CS_LEN);
        tsni_pkg::PH_SKIP_SID:  skip_step(2, tsni_pkg::PH_CS_LEN);
        tsni_pkg::PH_CS_LEN:    len16(b, tsni_pkg::PH_SKIP_CS, 1, tsni_pkg::PH_COMP_LEN);
        tsni_pkg::PH_SKIP_CS:   skip_step(1, tsni_pkg::PH_COMP_LEN);
        tsni_pkg::PH_COMP_LEN:  len8(b, tsni_pkg::PH_SKIP_COMP, 2, tsni_pkg::PH_EXT_TOTAL);
        tsni_pkg::PH_SKIP_COMP: skip_step(2, tsni_pkg::PH_EXT_TOTAL);
        tsni_pkg::PH_EXT_TOTAL: begin
          field_idx++;
          len_acc = {8'h00, len_acc[7:0], b};
          if (idx == 1) begin
            if (len_acc > record_left) begin
              flag_error(tsni_pkg::ST_OVERRUN);
            end else begin
              exts_left = len_acc[15:0];
              close_extension();
            end
          end
        end
        tsni_pkg::PH_EXT_HDR: begin
          field_idx++;
          if (idx == 0) ext_type = {8'h00, b};
          else if (idx == 1) ext_type = {ext_type[7:0], b};
          else len_acc = {8'h00, len_acc[7:0], b};
          if (idx == 3) begin
            if (len_acc > exts_left) begin
              flag_error(tsni_pkg::ST_OVERRUN);
            end else begin
              ext_left = len_acc[15:0];
              if (ext_type == tsni_pkg::EXT_SERVER_NAME) begin
                require(ext_left, 2, tsni_pkg::PH_SNI_LEN);
              end else if (ext_left != 0) begin
                phase = tsni_pkg::PH_EXT_SKIP;
              end else begin
                close_extension();
              end
            end
          end
        end
        tsni_pkg::PH_EXT_SKIP: begin
          if (ext_left == 0) close_extension();
        end
        tsni_pkg::PH_SNI_LEN: begin
          field_idx++;
          len_acc = {8'h00, len_acc[7:0], b};
          if (idx == 1) begin
            if (len_acc > ext_left) begin
              flag_error(tsni_pkg::ST_OVERRUN);
            end else begin
              list_left = len_acc[15:0];
              advance_name();
            end
          end
        end
        tsni_pkg::PH_NAME_HDR: begin
          field_idx++;
          if (idx == 0) host_name = (b == 8'h00);
          else len_acc = {8'h00, len_acc[7:0], b};
          if (idx == 2) begin
            if (len_acc > list_left) begin
              flag_error(tsni_pkg::ST_OVERRUN);
            end else begin
              name_left = len_acc[15:0];
              if (name_left != 0) phase = tsni_pkg::PH_NAME;
              else advance_name();
            end
          end
        end
        tsni_pkg::PH_NAME: begin
          if (host_name && mask_enable) begin
            r.byte_out = mask_char;
            r.masked = 1'b1;
          end
          if (name_left == 0) advance_name();
        end
        default: ;
      endcase

      if (last) begin
        if (phase == tsni_pkg::PH_ERR) r.status = first_error;
        else if (phase == tsni_pkg::PH_DONE) r.status = tsni_pkg::ST_OK;
        else r.status = tsni_pkg::ST_TRUNCATED;
        restart();
      end
      owed_q.push_back(r);
    endfunction

    function void check_result(tsni_pkg::result_t got);
      tsni_pkg::result_t want;
      if (owed_q.size() == 0) begin
        $error("output item with nothing owed: byte_out %0h status %0d",
               got.byte_out, got.status);
        failures++;
        return;
      end
      want = owed_q.pop_front();
      if (got.byte_out !== want.byte_out) begin
        $error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
        failures++;
      end
      if (got.masked !== want.masked) begin
        $error("masked: expected %0b, got %0b", want.masked, got.masked);
        failures++;
      end
      if (got.last_out !== want.last_out) begin
        $error("last_out: expected %0b, got %0b", want.last_out, got.last_out);
        failures++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hello_count = 0;

  sni_mask_scoreboard sb = new();

  tls_sni_hostname_masker DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    tsni_pkg::result_t got;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) begin
        got.byte_out = m_axis_tdata[7:0];
        got.status   = m_axis_tdata[10:8];
        got.masked   = m_axis_tuser;
        got.last_out = m_axis_tlast;
        sb.check_result(got);
      end
    end
  end

  // ---- stream building --------------------------------------------------

  function automatic void put16(ref octets_t q, input int unsigned v);
    q.push_back(8'(v >> 8));
    q.push_back(8'(v));
  endfunction

  function automatic void put_random(ref octets_t q, input int unsigned n);
    repeat (n) q.push_back(8'($urandom));
  endfunction

  function automatic void put_all(ref octets_t q, input octets_t src);
    foreach (src[i]) q.push_back(src[i]);
  endfunction

  function automatic octets_t sni_body();
    octets_t list;
    octets_t body;
    int unsigned n_names;
    int unsigned name_len;
    n_names = $urandom_range(0, 3);
    for (int i = 0; i < n_names; i++) begin
      name_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
      // mostly host_name entries, now and then some other name type
      list.push_back(($urandom_range(4) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
      put16(list, name_len);
      put_random(list, name_len);
    end
    put16(body, list.size());
    put_all(body, list);
    // stray bytes after the list are stepped over
    if ($urandom_range(4) == 0) put_random(body, $urandom_range(1, 3));
    return body;
  endfunction

  function automatic void put_extension(ref octets_t q, input bit is_sni);
    octets_t body;
    if (is_sni) body = sni_body();
    else put_random(body, $urandom_range(0, 6));
    put16(q, is_sni ? int'(tsni_pkg::EXT_SERVER_NAME) : $urandom_range(1, 16'hFFFF));
    put16(q, body.size());
    put_all(q, body);
  endfunction

  function automatic octets_t client_hello(input hello_fault_t fault);
    octets_t body;
    octets_t exts;
    octets_t s;
    int unsigned n_ext;
    int unsigned sni_at;
    int unsigned pad;
    int unsigned ext_pos;
    int unsigned hs_len;
    int unsigned cut;
    int unsigned v;
    cut = 0;
    n_ext = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
    sni_at = $urandom_range(0, n_ext);
    if (sni_at == n_ext && $urandom_range(1) == 0) sni_at = 0;
    for (int i = 0; i < n_ext; i++) put_extension(exts, i == sni_at);
    if (fault == F_PAD_CUT) pad = $urandom_range(1, 3);
    else pad = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;

    body.push_back(tsni_pkg::HS_CLIENT_HELLO);
    put_random(body, 3);   // hello length, patched below
    put_random(body, 34);  // version and random
    v = ($urandom_range(3) == 0) ? $urandom_range(1, 32) : 0;
    body.push_back(8'(v));
    put_random(body, v);
    v = 2 * $urandom_range(0, 4);
    put16(body, v);
    put_random(body, v);
    v = $urandom_range(0, 2);
    body.push_back(8'(v));
    put_random(body, v);
    ext_pos = body.size();
    put16(body, exts.size());
    put_all(body, exts);
    put_random(body, pad);

    hs_len = body.size() - 4;
    if (fault == F_SHORT_HELLO) hs_len--;
    if (fault == F_LONG_HELLO) hs_len += $urandom_range(1, 16'hFFFF);
    body[1] = 8'(hs_len >> 16);
    body[2] = 8'(hs_len >> 8);
    body[3] = 8'(hs_len);
    if (fault == F_EXT_OVERRUN) begin
      v = exts.size() + pad + 1 + $urandom_range(0, 3);
      body[ext_pos]   = 8'(v >> 8);
      body[ext_pos+1] = 8'(v);
    end

    if ($urandom_range(4) == 0) begin
      s = {tsni_pkg::REC_CCS, 8'h03, 8'h03, 8'h00, 8'h01, tsni_pkg::CCS_BODY};
    end
    s.push_back(tsni_pkg::REC_HANDSHAKE);
    s.push_back(8'h03);
    s.push_back(8'h01);
    put16(s, body.size());
    put_all(s, body);

    case (fault)
      F_FLIP: begin
        v = $urandom_range(0, s.size() - 1);
        s[v] = s[v] ^ 8'($urandom_range(1, 255));
      end
      F_TRUNCATE:    cut = $urandom_range(1, s.size() - 1);
      F_PAD_CUT:     cut = s.size() - $urandom_range(1, pad);
      F_PAST_RECORD: put_random(s, $urandom_range(1, 3));
      default: ;
    endcase
    if (cut != 0) while (s.size() > cut) void'(s.pop_back());
    return s;
  endfunction

  function automatic octets_t next_stream();
    octets_t s;
    hello_fault_t fault;
    if ($urandom_range(99) < 12) begin
      case ($urandom_range(2))
        0: s.push_back(tsni_pkg::REC_HANDSHAKE);
        1: s.push_back(tsni_pkg::REC_CCS);
        default: s.push_back(8'($urandom));
      endcase
      put_random(s, $urandom_range(0, 5));
      return s;
    end
    // walk every fault kind once before drawing them at random
    if (hello_count < FAULT_KINDS) fault = hello_fault_t'(hello_count);
    else if ($urandom_range(99) < 55) fault = F_NONE;
    else fault = hello_fault_t'($urandom_range(1, FAULT_KINDS - 1));
    hello_count++;
    return client_hello(fault);
  endfunction

  // ---- drivers ----------------------------------------------------------

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  task automatic send_stream(input octets_t s, input int pause_at);
    foreach (s[i]) begin
      if (i == pause_at) wait_for_drain();
      push_byte(s[i], i == s.size() - 1);
    end
  endtask

  task automatic apply_settings(input logic [7:0] ch, input logic en);
    logic [7:0] en_word;
    // junk in the upper bits must be ignored
    en_word = {7'($urandom), en};
    cfg_wr_en <= 1'b1;
    cfg_index <= tsni_pkg::CFG_MASK_CHAR;
    cfg_wdata <= ch;
    @(posedge clk);
    cfg_index <= tsni_pkg::CFG_MASK_ENABLE;
    cfg_wdata <= en_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_register(tsni_pkg::CFG_MASK_CHAR, ch);
    sb.set_register(tsni_pkg::CFG_MASK_ENABLE, en_word);
  endtask

  initial begin
    #5_000_000;
    $display("tls_sni_hostname_masker regression: fail");
    $finish;
  end

  initial begin
    octets_t s;
    int unsigned run_bytes;
    int unsigned n_in_run;
    int pause_at;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: wrong record type, bad CCS length and body, short record,
    // and a good CCS followed by a handshake that is not a ClientHello
    s = {8'h00};
    send_stream(s, -1);
    s = {tsni_pkg::REC_CCS, 8'h03, 8'h03, 8'h00, 8'h02};
    send_stream(s, -1);
    s = {tsni_pkg::REC_CCS, 8'h03, 8'h03, 8'h00, 8'h01, 8'h00};
    send_stream(s, -1);
    s = {tsni_pkg::REC_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'(tsni_pkg::MIN_RECORD_LEN - 1)};
    send_stream(s, -1);
    s = {tsni_pkg::REC_CCS, 8'h03, 8'h03, 8'h00, 8'h01, tsni_pkg::CCS_BODY,
         tsni_pkg::REC_HANDSHAKE, 8'h03, 8'h01, 8'h00, 8'(tsni_pkg::MIN_RECORD_LEN),
         8'h02};
    send_stream(s, -1);

    for (int run = 0; run < RUNS; run++) begin
      if (run != 0) begin
        wait_for_drain();
        repeat (4) @(posedge clk);
        case (run)
          1: apply_settings(8'h00, 1'b1);
          2: apply_settings(8'hFF, 1'b1);
          3: apply_settings(8'($urandom), 1'b0);
          default: apply_settings(8'($urandom), 1'b1);
        endcase
      end
      send_gap_pct = GAP_PCT[run];
      recv_stall_pct = STALL_PCT[run];
      run_bytes = 0;
      n_in_run = 0;
      while (run_bytes < BYTES_PER_RUN) begin
        s = next_stream();
        // hold the sender mid-stream once per run until the output catches up
        pause_at = (n_in_run == 1) ? s.size() / 2 : -1;
        send_stream(s, pause_at);
        run_bytes += s.size();
        n_in_run++;
      end
    end

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("tls_sni_hostname_masker regression: pass");
    end else begin
      $display("tls_sni_hostname_masker regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
src/tsni_pkg.sv
src/tsni_parser.sv
src/tls_sni_hostname_masker.sv
verif/tls_sni_hostname_masker_tb.sv
